// ----- hdl/kxs_pkg.sv -----
// ----------------------------------------------------------------------------
// kxs_pkg
// Shared constants and a helper function for the keyed XOR byte scrambler.
// ----------------------------------------------------------------------------
package kxs_pkg;

  // Default depth of the command text store
  localparam int unsigned KXS_TEXT_LEN = 1024;

  // Fixed field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned TADDR_W = 10;
  localparam int unsigned BYTE_W  = 8;

  // Input word operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_DATA  = 2'd2;

  // Character substitution constants
  localparam logic [BYTE_W-1:0] CHAR_MAX_PLAIN = 8'd127;
  localparam logic [BYTE_W-1:0] CHAR_PERCENT   = 8'h25;
  localparam logic [BYTE_W-1:0] CHAR_DOT       = 8'h2E;

  // Replace high-bit characters and the percent sign by a dot
  function automatic logic [BYTE_W-1:0] kxs_clean_char(input logic [BYTE_W-1:0] c);
    if (c > CHAR_MAX_PLAIN || c == CHAR_PERCENT) begin
      return CHAR_DOT;
    end
    return c;
  endfunction

endpackage

// ----- hdl/kxs_ram.sv -----
// ----------------------------------------------------------------------------
// kxs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module kxs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/keyed_xor_byte_scrambler.sv -----
// ----------------------------------------------------------------------------
// keyed_xor_byte_scrambler
// Scrambles or unscrambles message bytes with a key that evolves from a
// stored command text. Encoding and decoding are the same operation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per handshake. A load
//   word writes one text character into the store; a start word seeds the key
//   from cfg challenge ^ seed_a ^ seed_b, sets the parity and rewinds the
//   text index; a data word yields one scrambled byte on the output channel
//   (out_valid/out_ready). Load and start words, and op code 3, give nothing.
//   A data word's result is registered into out_byte as the word is accepted.
//   Throughput: one word per cycle, any mix of operations, while not stalled.
//   The text RAM is read every cycle at the index the next word will use; the
//   read address comes from the char read in the same cycle, and a load that
//   hits the address being read is forwarded, so no stall is ever needed.
//   Reset clears key, index, parity, challenge and the output valid flag; the
//   text store is not cleared and must be loaded before it is used.
//   When the receiver stalls, out_byte holds and in_ready drops until the
//   output register is taken; in_ready follows out_ready in the same cycle.
//   cfg_wr_en may be asserted only while no word is in flight.
// ----------------------------------------------------------------------------
module keyed_xor_byte_scrambler
  import kxs_pkg::*;
#(
  parameter int unsigned TEXT_LEN = KXS_TEXT_LEN
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [BYTE_W-1:0]  cfg_wr_data,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_op,
  input  logic [TADDR_W-1:0] in_text_addr,
  input  logic [BYTE_W-1:0]  in_value,
  input  logic [BYTE_W-1:0]  in_seed_a,
  input  logic [BYTE_W-1:0]  in_seed_b,
  input  logic               in_start_parity,
  // result words
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte
);

  localparam int unsigned AW    = $clog2(TEXT_LEN);
  localparam int unsigned IDX_W = $clog2(TEXT_LEN + 1);

  // State registers
  logic [BYTE_W-1:0] challenge_r;
  logic [BYTE_W-1:0] key_r,      key_nxt;
  logic [IDX_W-1:0]  index_r,    index_nxt;
  logic              parity_r,   parity_nxt;
  logic [BYTE_W-1:0] char0_r;
  logic              fwd_hit_r;
  logic [BYTE_W-1:0] fwd_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r,  out_byte_nxt;

  // Datapath
  logic              in_fire;
  logic              load_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [IDX_W-1:0]  rd_idx;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] mem_char;
  logic              past_end;
  logic              wrap;
  logic [BYTE_W-1:0] cur_char;
  logic [BYTE_W-1:0] clean_char;
  logic [BYTE_W-1:0] key_upd;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;

  // Load words within the store write the text RAM
  assign load_en = in_fire && (in_op == OP_LOAD)
                   && (32'(in_text_addr) < 32'(TEXT_LEN));
  assign wr_addr = AW'(in_text_addr);

  // Character at the current index, with write forwarding and wrap to entry zero
  assign mem_char   = fwd_hit_r ? fwd_data_r : rd_data;
  assign past_end   = (index_r >= IDX_W'(TEXT_LEN));
  assign wrap       = past_end || (mem_char == '0);
  assign cur_char   = wrap ? char0_r : mem_char;
  assign clean_char = kxs_clean_char(cur_char);
  assign key_upd    = key_r ^ (parity_r ? {clean_char[BYTE_W-2:0], 1'b0} : clean_char);

  // Next state per accepted word
  always_comb begin
    key_nxt       = key_r;
    index_nxt     = index_r;
    parity_nxt    = parity_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    if (in_fire) begin
      unique case (in_op)
        OP_LOAD: begin
          key_nxt = key_r;
        end
        OP_START: begin
          key_nxt    = challenge_r ^ in_seed_a ^ in_seed_b;
          parity_nxt = in_start_parity;
          index_nxt  = '0;
        end
        OP_DATA: begin
          key_nxt       = key_upd;
          index_nxt     = wrap ? IDX_W'(1) : index_r + IDX_W'(1);
          parity_nxt    = !parity_r;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = in_value ^ key_upd;
        end
        default: begin
          key_nxt = key_r;
        end
      endcase
    end
  end

  // Prefetch the character the next word will use
  assign rd_idx  = rst_n ? index_nxt : '0;
  assign rd_addr = (rd_idx >= IDX_W'(TEXT_LEN)) ? '0 : AW'(rd_idx);

  kxs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TEXT_LEN)
  ) u_text_ram (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      challenge_r <= '0;
      key_r       <= '0;
      index_r     <= '0;
      parity_r    <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        challenge_r <= cfg_wr_data;
      end
      key_r       <= key_nxt;
      index_r     <= index_nxt;
      parity_r    <= parity_nxt;
      fwd_hit_r   <= load_en && (wr_addr == rd_addr);
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: shadow of entry zero, forwarded write, output word
  always_ff @(posedge clk) begin
    if (load_en && wr_addr == '0) begin
      char0_r <= in_value;
    end
    fwd_data_r <= in_value;
    out_byte_r <= out_byte_nxt;
  end

  // Assertions
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    index_r <= IDX_W'(TEXT_LEN))
    else $error("text index beyond store length");

  a_start_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_op == OP_START |=> index_r == '0 && parity_r == $past(in_start_parity))
    else $error("start word did not rewind index and set parity");

  a_data_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_op == OP_DATA |=> out_valid_r && parity_r != $past(parity_r)
                                    && index_r != '0)
    else $error("data word did not produce a result and advance");

  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> $past(load_en))
    else $error("forward hit without a preceding load");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r && !out_ready)
    else $error("input stalled while output register free");

endmodule

// ----- sim/keyed_xor_byte_scrambler_checker.sv -----
// ----------------------------------------------------------------------------
// keyed_xor_byte_scrambler_checker
// Watches the word and result channels of the scrambler, keeps its own copy of
// the text store, key, index and parity, and compares each scrambled byte in
// order against the byte worked out for it.
// ----------------------------------------------------------------------------
module keyed_xor_byte_scrambler_checker
  import kxs_pkg::*;
#(
  parameter int unsigned TEXT_LEN = KXS_TEXT_LEN
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [BYTE_W-1:0]  cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [OP_W-1:0]    in_op,
  input  logic [TADDR_W-1:0] in_text_addr,
  input  logic [BYTE_W-1:0]  in_value,
  input  logic [BYTE_W-1:0]  in_seed_a,
  input  logic [BYTE_W-1:0]  in_seed_b,
  input  logic               in_start_parity,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [BYTE_W-1:0]  out_byte,
  output int                 mismatch_count,
  output int                 bytes_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the block state
  logic [BYTE_W-1:0] text_shadow [TEXT_LEN];
  logic [BYTE_W-1:0] key_now;
  logic [BYTE_W-1:0] challenge_now;
  logic              parity_now;
  int unsigned       text_pos;

  logic [BYTE_W-1:0] expected_bytes [$];
  int                errors;

  // Fold the next text character into the key and scramble one message byte
  function automatic logic [BYTE_W-1:0] scramble_byte(input logic [BYTE_W-1:0] msg);
    logic [BYTE_W-1:0] ch;
    if (text_pos >= TEXT_LEN || text_shadow[text_pos] == '0) begin
      text_pos = 0;
    end
    ch = text_shadow[text_pos];
    if (ch > CHAR_MAX_PLAIN || ch == CHAR_PERCENT) begin
      ch = CHAR_DOT;
    end
    key_now = key_now ^ (parity_now ? {ch[BYTE_W-2:0], 1'b0} : ch);
    text_pos++;
    parity_now = ~parity_now;
    return msg ^ key_now;
  endfunction

  always @(posedge clk) begin
    logic [BYTE_W-1:0] want;
    if (!rst_n) begin
      key_now       = '0;
      challenge_now = '0;
      parity_now    = 1'b0;
      text_pos      = 0;
      errors        = 0;
      expected_bytes.delete();
    end else begin
      // Compare a taken result word with the oldest byte owed
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected out_byte, expected nothing, actual %02h", $time, out_byte);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want, out_byte);
            errors++;
          end
        end
      end
      // Track the challenge register
      if (cfg_wr_en) begin
        challenge_now = cfg_wr_data;
      end
      // Advance the shadow state on each accepted word
      if (in_valid && in_ready) begin
        case (in_op)
          OP_LOAD: begin
            if (in_text_addr < TEXT_LEN) begin
              text_shadow[in_text_addr] = in_value;
            end
          end
          OP_START: begin
            key_now    = challenge_now ^ in_seed_a ^ in_seed_b;
            parity_now = in_start_parity;
            text_pos   = 0;
          end
          OP_DATA: begin
            expected_bytes.push_back(scramble_byte(in_value));
          end
          default: begin
          end
        endcase
      end
    end
    mismatch_count <= errors;
    bytes_owed     <= expected_bytes.size();
  end

endmodule

// ----- sim/keyed_xor_byte_scrambler_tb.sv -----
// ----------------------------------------------------------------------------
// keyed_xor_byte_scrambler_tb
// Drives text loads, message starts and data bytes into the scrambler with
// bursty input and a stalling receiver, changes the challenge between
// messages, and reports the verdict from the checker's mismatch and owed-byte counts.
// ----------------------------------------------------------------------------
module keyed_xor_byte_scrambler_tb
  import kxs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned     STORE_LEN = KXS_TEXT_LEN;
  localparam int              RANDOM_WORDS = 1500;

  typedef enum int {RX_STREAM, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [BYTE_W-1:0]  cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic [OP_W-1:0]    in_op;
  logic [TADDR_W-1:0] in_text_addr;
  logic [BYTE_W-1:0]  in_value;
  logic [BYTE_W-1:0]  in_seed_a;
  logic [BYTE_W-1:0]  in_seed_b;
  logic               in_start_parity;
  logic               out_valid;
  logic               out_ready;
  logic [BYTE_W-1:0]  out_byte;
  int                 mismatch_count;
  int                 bytes_owed;

  int       burst_left = 0;
  int       stall_left = 0;
  int       stall_tick = 0;
  rx_mode_t stall_mode = RX_STREAM;

  keyed_xor_byte_scrambler #(
    .TEXT_LEN(STORE_LEN)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_text_addr   (in_text_addr),
    .in_value       (in_value),
    .in_seed_a      (in_seed_a),
    .in_seed_b      (in_seed_b),
    .in_start_parity(in_start_parity),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte)
  );

  keyed_xor_byte_scrambler_checker #(
    .TEXT_LEN(STORE_LEN)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_text_addr   (in_text_addr),
    .in_value       (in_value),
    .in_seed_a      (in_seed_a),
    .in_seed_b      (in_seed_b),
    .in_start_parity(in_start_parity),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .mismatch_count (mismatch_count),
    .bytes_owed     (bytes_owed)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: switch between streaming, light, heavy and periodic stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      RX_STREAM:   out_ready <= 1'b1;
      RX_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:    out_ready <= ($urandom_range(0, 3) == 0);
      default:     out_ready <= ((stall_tick % 5) < 2);
    endcase
  end

  // Pick a text character, weighted towards the substituted ones
  function automatic logic [BYTE_W-1:0] pick_text_char(input bit allow_zero);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      return allow_zero ? 8'h00 : 8'h41;
    end else if (r == 1) begin
      return CHAR_PERCENT;
    end else if (r <= 5) begin
      return 8'($urandom_range(128, 255));
    end else if (r == 6) begin
      return CHAR_MAX_PLAIN;
    end
    return 8'($urandom_range(1, 127));
  endfunction

  // Offer one word, opening a new burst with a random gap when the last ends
  task automatic send_word(input logic [OP_W-1:0] op, input logic [TADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] val, input logic [BYTE_W-1:0] sa,
                           input logic [BYTE_W-1:0] sb, input logic sp);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_op           <= op;
    in_text_addr    <= addr;
    in_value        <= val;
    in_seed_a       <= sa;
    in_seed_b       <= sb;
    in_start_parity <= sp;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every byte owed has come out
  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (bytes_owed != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_challenge(input logic [BYTE_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int i;
    int j;
    int n;
    int r;
    int msg_count;
    int random_words;
    logic [55:0] probe_bytes;

    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_valid        <= 1'b0;
    in_op           <= OP_LOAD;
    in_text_addr    <= '0;
    in_value        <= '0;
    in_seed_a       <= '0;
    in_seed_b       <= '0;
    in_start_parity <= 1'b0;
    out_ready       <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole store with non-zero text so that every read is defined
    for (i = 0; i < STORE_LEN; i++) begin
      send_word(OP_LOAD, TADDR_W'(i), pick_text_char(1'b0), 8'($urandom), 8'($urandom),
                1'($urandom));
    end
    drain_results();
    write_challenge(8'h3C);

    // One long message runs off the end of the store and wraps
    send_word(OP_START, 10'h2AA, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    for (i = 0; i < STORE_LEN + 6; i++) begin
      send_word(OP_DATA, TADDR_W'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom));
    end
    drain_results();
    write_challenge(8'hFF);

    // Empty text: a zero at the head is used as is and the index still moves
    send_word(OP_LOAD, 10'd0, 8'h00, 8'h00, 8'h00, 1'b0);
    send_word(OP_START, 10'h3FF, 8'hFF, 8'h00, 8'h00, 1'b0);
    send_word(OP_DATA, 10'h000, 8'h00, 8'hFF, 8'hFF, 1'b1);
    send_word(OP_DATA, 10'h3FF, 8'hFF, 8'h00, 8'h00, 1'b0);

    // Substituted characters, then a wrap at a terminator, with odd parity
    send_word(OP_LOAD, 10'd0, 8'h41, 8'h00, 8'h00, 1'b0);
    send_word(OP_LOAD, 10'd1, CHAR_PERCENT, 8'h00, 8'h00, 1'b0);
    send_word(OP_LOAD, 10'd2, 8'h80, 8'h00, 8'h00, 1'b0);
    send_word(OP_LOAD, 10'd3, 8'h7F, 8'h00, 8'h00, 1'b0);
    send_word(OP_LOAD, 10'd4, 8'hFF, 8'h00, 8'h00, 1'b0);
    send_word(OP_LOAD, 10'd5, 8'h00, 8'h00, 8'h00, 1'b0);
    send_word(OP_LOAD, 10'h3FF, 8'h01, 8'h00, 8'h00, 1'b0);
    send_word(OP_START, 10'h000, 8'h00, 8'hFF, 8'hFF, 1'b1);
    probe_bytes = 56'h7F_80_01_AA_55_FF_00;
    for (i = 0; i < 7; i++) begin
      send_word(OP_DATA, TADDR_W'(i), probe_bytes[8*i +: 8], 8'h00, 8'h00, 1'b0);
    end

    // Unused op code gives nothing and leaves the key alone
    send_word(OP_UNUSED, 10'h3FF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_word(OP_START, 10'h155, 8'h00, 8'h5A, 8'h00, 1'b0);
    send_word(OP_DATA, 10'h0AA, 8'hC3, 8'h00, 8'h00, 1'b1);
    drain_results();
    write_challenge(8'h00);

    // Random messages: edit the text, usually start, then a run of mostly data bytes
    msg_count    = 0;
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      if (msg_count % 10 == 9) begin
        drain_results();
        r = $urandom_range(0, 3);
        write_challenge(r == 0 ? 8'h00 : r == 1 ? 8'hFF : 8'($urandom));
      end
      n = $urandom_range(0, 6);
      for (j = 0; j < n; j++) begin
        send_word(OP_LOAD,
                  ($urandom_range(0, 7) == 0) ? TADDR_W'($urandom)
                                              : TADDR_W'($urandom_range(0, 47)),
                  pick_text_char(1'b1), 8'($urandom), 8'($urandom), 1'($urandom));
        random_words++;
      end
      // Drop in a terminator now and then so that short texts wrap often
      if ($urandom_range(0, 2) == 0) begin
        send_word(OP_LOAD, TADDR_W'($urandom_range(0, 40)), 8'h00, 8'($urandom), 8'($urandom),
                  1'($urandom));
        random_words++;
      end
      if ($urandom_range(0, 9) != 0) begin
        send_word(OP_START, TADDR_W'($urandom), 8'($urandom), 8'($urandom),
                  ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom), 1'($urandom));
        random_words++;
      end
      n = $urandom_range(1, 40);
      for (j = 0; j < n; j++) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          send_word(OP_UNUSED, TADDR_W'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    1'($urandom));
        end else if (r == 1) begin
          send_word(OP_LOAD, TADDR_W'($urandom), pick_text_char(1'b1), 8'($urandom),
                    8'($urandom), 1'($urandom));
          random_words++;
        end else begin
          send_word(OP_DATA, TADDR_W'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    1'($urandom));
          random_words++;
        end
      end
      msg_count++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && bytes_owed == 0) begin
      $display("keyed_xor_byte_scrambler test passed");
    end else begin
      $display("keyed_xor_byte_scrambler test failed");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("keyed_xor_byte_scrambler test failed");
    $finish;
  end

endmodule

// ----- keyed_xor_byte_scrambler.f -----
hdl/kxs_pkg.sv
hdl/kxs_ram.sv
hdl/keyed_xor_byte_scrambler.sv
sim/keyed_xor_byte_scrambler_checker.sv
sim/keyed_xor_byte_scrambler_tb.sv
